// File: rtl/core/mpq_pkg.sv
// shared constants for the min priority queue: field widths, action and status codes
`default_nettype none

package mpq_pkg;

  localparam int DATA_W = 32;
  localparam int ACT_W  = 2;
  localparam int ST_W   = 2;

  localparam int CAPACITY_DEF    = 1024;
  localparam int VALUE_WIDTH_DEF = 32;

  localparam logic [ACT_W-1:0] ACT_INSERT = 2'd0;
  localparam logic [ACT_W-1:0] ACT_PEEK   = 2'd1;
  localparam logic [ACT_W-1:0] ACT_POP    = 2'd2;

  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

endpackage

`default_nettype wire

// File: rtl/core/min_priority_queue.sv
// min priority queue held as a binary heap in one memory, sifted by a small sequencer
//
// channel  | handshake           | payload
// ---------+---------------------+------------------------
// request  | in_valid, in_stall  | action, value
// result   | out_valid, out_stall| status, min_value
//
// insert: climbs one level per parent read and compare, stopping at the root or where the parent is not larger
// pop: moves the last entry to the root, then descends one level per left read, right read and compare
// peek, pop of the last entry and pop on empty only read the root; a rejected insert and a reserved action read none
// rst is synchronous and clears the entry count; the heap memory is not cleared
// a finished result waits in the output register while out_stall is high
`default_nettype none

module min_priority_queue #(
  parameter int CAPACITY    = mpq_pkg::CAPACITY_DEF,
  parameter int VALUE_WIDTH = mpq_pkg::VALUE_WIDTH_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic [mpq_pkg::ACT_W-1:0]       action,
  input  wire logic signed [mpq_pkg::DATA_W-1:0] value,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic [mpq_pkg::ST_W-1:0]             status,
  output logic signed [mpq_pkg::DATA_W-1:0]    min_value
);
  import mpq_pkg::*;

  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int AW   = $clog2(CAPACITY);
  localparam int LW   = AW + 2;
  localparam int IN_W = (VALUE_WIDTH < DATA_W) ? VALUE_WIDTH : DATA_W;

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_UP_RD    = 4'd1;
  localparam logic [3:0] S_UP_CMP   = 4'd2;
  localparam logic [3:0] S_DN_LAST  = 4'd3;
  localparam logic [3:0] S_DN_L     = 4'd4;
  localparam logic [3:0] S_DN_R     = 4'd5;
  localparam logic [3:0] S_DN_CMP   = 4'd6;
  localparam logic [3:0] S_TOP_RD   = 4'd7;
  localparam logic [3:0] S_TOP_WAIT = 4'd8;
  localparam logic [3:0] S_DONE     = 4'd9;
  localparam logic [3:0] S_SKIP     = 4'd10;

  logic [VALUE_WIDTH-1:0] heap_mem [CAPACITY];

  logic [3:0]             state;
  logic [CW-1:0]          count;
  logic [AW-1:0]          pos;
  logic [VALUE_WIDTH-1:0] cur;
  logic [VALUE_WIDTH-1:0] lval;
  logic                   has_right;
  logic [ST_W-1:0]        res_status;
  logic [DATA_W-1:0]      res_value;

  logic [AW-1:0]          rd_addr;
  logic [VALUE_WIDTH-1:0] rd_data;
  logic                   wr_en;
  logic [VALUE_WIDTH-1:0] wr_data;

  logic                   in_xfer;
  logic [VALUE_WIDTH-1:0] in_val;
  logic [AW-1:0]          parent;
  logic [AW-1:0]          last_idx;
  logic [LW-1:0]          left;
  logic [LW-1:0]          right;
  logic [LW-1:0]          count_ext;
  logic                   up_less;
  logic                   sel_left;
  logic [VALUE_WIDTH-1:0] min_lc;
  logic                   sel_right;
  logic                   out_free;

  assign in_stall  = (state != S_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign in_val    = VALUE_WIDTH'(value[IN_W-1:0]);
  assign parent    = (pos - AW'(1)) >> 1;
  assign last_idx  = AW'(count - CW'(1));
  assign left      = {1'b0, pos, 1'b1};
  assign right     = left + LW'(1);
  assign count_ext = LW'(count);
  assign up_less   = $signed(cur) < $signed(rd_data);
  assign sel_left  = $signed(lval) < $signed(cur);
  assign min_lc    = sel_left ? lval : cur;
  assign sel_right = has_right && ($signed(rd_data) < $signed(min_lc));
  assign out_free  = !out_valid || !out_stall;

  always_comb begin
    case (state)
      S_UP_RD:  rd_addr = parent;
      S_DN_L:   rd_addr = AW'(left);
      S_DN_R:   rd_addr = AW'(right);
      S_TOP_RD: rd_addr = '0;
      default:  rd_addr = last_idx;
    endcase
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_data = cur;
    case (state)
      S_UP_RD: begin
        wr_en = (pos == '0);
      end
      S_UP_CMP: begin
        wr_en   = 1'b1;
        wr_data = up_less ? rd_data : cur;
      end
      S_DN_L: begin
        wr_en = (left >= count_ext);
      end
      S_DN_CMP: begin
        wr_en   = 1'b1;
        wr_data = sel_right ? rd_data : min_lc;
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      heap_mem[pos] <= wr_data;
    end
    rd_data <= heap_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (state == S_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_xfer) begin
            case (action)
              ACT_INSERT: begin
                if (count == CW'(CAPACITY)) begin
                  res_status <= ST_FULL;
                  res_value  <= '0;
                  state      <= S_DONE;
                end else begin
                  cur   <= in_val;
                  pos   <= AW'(count);
                  count <= count + CW'(1);
                  state <= S_UP_RD;
                end
              end
              ACT_PEEK: begin
                state <= S_TOP_RD;
              end
              ACT_POP: begin
                if (count == '0) begin
                  state <= S_TOP_RD;
                end else if (count == CW'(1)) begin
                  count <= '0;
                  state <= S_TOP_RD;
                end else begin
                  count <= count - CW'(1);
                  pos   <= '0;
                  state <= S_DN_LAST;
                end
              end
              default: begin
                state <= S_SKIP;
              end
            endcase
          end
        end
        S_UP_RD: begin
          state <= (pos == '0) ? S_TOP_RD : S_UP_CMP;
        end
        S_UP_CMP: begin
          if (up_less) begin
            pos   <= parent;
            state <= S_UP_RD;
          end else begin
            state <= S_TOP_RD;
          end
        end
        S_DN_LAST: begin
          cur   <= rd_data;
          state <= S_DN_L;
        end
        S_DN_L: begin
          if (left >= count_ext) begin
            state <= S_TOP_RD;
          end else begin
            has_right <= (right < count_ext);
            state     <= S_DN_R;
          end
        end
        S_DN_R: begin
          lval  <= rd_data;
          state <= S_DN_CMP;
        end
        S_DN_CMP: begin
          if (sel_right) begin
            pos   <= AW'(right);
            state <= S_DN_L;
          end else if (sel_left) begin
            pos   <= AW'(left);
            state <= S_DN_L;
          end else begin
            state <= S_TOP_RD;
          end
        end
        S_TOP_RD: begin
          state <= S_TOP_WAIT;
        end
        S_TOP_WAIT: begin
          if (count == '0) begin
            res_status <= ST_EMPTY;
            res_value  <= '0;
          end else begin
            res_status <= ST_OK;
            res_value  <= DATA_W'(rd_data[IN_W-1:0]);
          end
          state <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            status    <= res_status;
            min_value <= res_value;
            state     <= S_IDLE;
          end
        end
        S_SKIP: begin
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/mpq_checker.sv
// port-level checks for the min priority queue, bound to the top level
`default_nettype none

module mpq_checker (
  input wire logic                        clk,
  input wire logic                        rst,
  input wire logic                        in_valid,
  input wire logic                        in_stall,
  input wire logic                        out_valid,
  input wire logic                        out_stall,
  input wire logic [mpq_pkg::ST_W-1:0]    status,
  input wire logic [mpq_pkg::DATA_W-1:0]  min_value
);
  import mpq_pkg::*;

  // a waiting result holds still
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(status) && $stable(min_value))
    else $error("result changed while stalled");

  // only a valid minimum carries a value
  a_zero_value: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != ST_OK) |-> (min_value == '0))
    else $error("nonzero value with empty or full status");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status == ST_OK || status == ST_EMPTY || status == ST_FULL))
    else $error("unknown status code");

  // every request transfer keeps the block busy for at least the next cycle
  a_busy_after: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("request taken while previous one in work");

  a_reset_clear: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result pending after reset");

endmodule

bind min_priority_queue mpq_checker u_mpq_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .status    (status),
  .min_value (min_value)
);

`default_nettype wire

// File: verif/tb_min_priority_queue.sv
// self-checking testbench for min_priority_queue: directed table, then random heap traffic
`timescale 1ns / 1ps

module tb_min_priority_queue;
  import mpq_pkg::*;

  localparam int HEAP_DEPTH = CAPACITY_DEF;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int DRAIN_CYCLES = 60;
  localparam int LONG_HOLD_CYCLES = 600;
  localparam logic [ACT_W-1:0] ACT_RSVD = 2'd3;

  typedef struct packed {
    logic [ST_W-1:0] st;
    logic signed [DATA_W-1:0] mv;
  } min_result_t;

  typedef struct packed {
    logic [ACT_W-1:0] act;
    logic [DATA_W-1:0] val;
    logic typed;
    logic [ST_W-1:0] st;
    logic [DATA_W-1:0] mv;
  } request_row_t;

  // typed rows carry their own expected result, others go through the heap predictor
  localparam request_row_t DIRECTED_ROWS [25] = '{
    '{ACT_PEEK,   32'h0000_0000, 1'b1, ST_EMPTY, 32'h0000_0000},
    '{ACT_POP,    32'h0000_0000, 1'b1, ST_EMPTY, 32'h0000_0000},
    '{ACT_RSVD,   32'hA5A5_A5A5, 1'b0, ST_OK,    32'h0000_0000},
    '{ACT_INSERT, 32'h0000_0005, 1'b1, ST_OK,    32'h0000_0005},
    '{ACT_INSERT, 32'h7FFF_FFFF, 1'b1, ST_OK,    32'h0000_0005},
    '{ACT_INSERT, 32'h8000_0000, 1'b1, ST_OK,    32'h8000_0000},
    '{ACT_INSERT, 32'hFFFF_FFFF, 1'b1, ST_OK,    32'h8000_0000},
    '{ACT_PEEK,   32'hFFFF_FFFF, 1'b1, ST_OK,    32'h8000_0000},
    '{ACT_POP,    32'h1234_5678, 1'b1, ST_OK,    32'hFFFF_FFFF},
    '{ACT_POP,    32'h0000_0000, 1'b1, ST_OK,    32'h0000_0005},
    '{ACT_INSERT, 32'h0000_0005, 1'b1, ST_OK,    32'h0000_0005},
    '{ACT_RSVD,   32'h0000_0000, 1'b0, ST_OK,    32'h0000_0000},
    '{ACT_POP,    32'h0000_0000, 1'b1, ST_OK,    32'h0000_0005},
    '{ACT_POP,    32'h0000_0000, 1'b1, ST_OK,    32'h7FFF_FFFF},
    '{ACT_POP,    32'h0000_0000, 1'b1, ST_EMPTY, 32'h0000_0000},
    '{ACT_POP,    32'hFFFF_FFFF, 1'b1, ST_EMPTY, 32'h0000_0000},
    '{ACT_INSERT, 32'h0000_0000, 1'b1, ST_OK,    32'h0000_0000},
    '{ACT_INSERT, 32'h0000_0001, 1'b1, ST_OK,    32'h0000_0000},
    '{ACT_INSERT, 32'hFFFF_FFFE, 1'b1, ST_OK,    32'hFFFF_FFFE},
    '{ACT_INSERT, 32'h8000_0001, 1'b0, ST_OK,    32'h0000_0000},
    '{ACT_POP,    32'h0000_0000, 1'b0, ST_OK,    32'h0000_0000},
    '{ACT_PEEK,   32'h0000_0000, 1'b0, ST_OK,    32'h0000_0000},
    '{ACT_POP,    32'h0000_0000, 1'b0, ST_OK,    32'h0000_0000},
    '{ACT_POP,    32'h0000_0000, 1'b0, ST_OK,    32'h0000_0000},
    '{ACT_POP,    32'h0000_0000, 1'b1, ST_EMPTY, 32'h0000_0000}
  };

  logic clk;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [ACT_W-1:0] action = ACT_PEEK;
  logic signed [DATA_W-1:0] value = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [ST_W-1:0] status;
  logic signed [DATA_W-1:0] min_value;

  logic signed [DATA_W-1:0] heap_vals [HEAP_DEPTH];
  int heap_count = 0;
  min_result_t expected_mins [$];
  min_result_t oldest_min;
  int errors = 0;
  int cycle_count = 0;
  int full_hits = 0;
  int sent_count = 0;
  bit idle_mode = 1'b1;
  bit quiet = 1'b0;
  bit long_hold_due = 1'b0;
  bit long_hold_done = 1'b0;

  min_priority_queue dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .action(action),
    .value(value),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .status(status),
    .min_value(min_value)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic void report_min(output logic [ST_W-1:0] st,
                                     output logic signed [DATA_W-1:0] mv);
    if (heap_count == 0) begin
      st = ST_EMPTY;
      mv = '0;
    end else begin
      st = ST_OK;
      mv = heap_vals[0];
    end
  endfunction

  function automatic bit predict_min(input logic [ACT_W-1:0] act,
                                     input logic signed [DATA_W-1:0] val,
                                     output logic [ST_W-1:0] st,
                                     output logic signed [DATA_W-1:0] mv);
    int pos;
    int best;
    int left;
    logic signed [DATA_W-1:0] tmp;
    bit sifting;
    st = ST_OK;
    mv = '0;
    case (act)
      ACT_INSERT: begin
        if (heap_count >= HEAP_DEPTH) begin
          st = ST_FULL;
          return 1'b1;
        end
        pos = heap_count;
        heap_vals[pos] = val;
        heap_count++;
        while (pos > 0 && heap_vals[pos] < heap_vals[(pos - 1) / 2]) begin
          tmp = heap_vals[pos];
          heap_vals[pos] = heap_vals[(pos - 1) / 2];
          heap_vals[(pos - 1) / 2] = tmp;
          pos = (pos - 1) / 2;
        end
      end
      ACT_PEEK: begin
      end
      ACT_POP: begin
        if (heap_count > 0) begin
          heap_count--;
          heap_vals[0] = heap_vals[heap_count];
          pos = 0;
          sifting = 1'b1;
          while (sifting) begin
            left = 2 * pos + 1;
            best = pos;
            if (left < heap_count && heap_vals[left] < heap_vals[best]) best = left;
            if (left + 1 < heap_count && heap_vals[left + 1] < heap_vals[best]) best = left + 1;
            if (best == pos) begin
              sifting = 1'b0;
            end else begin
              tmp = heap_vals[pos];
              heap_vals[pos] = heap_vals[best];
              heap_vals[best] = tmp;
              pos = best;
            end
          end
        end
      end
      default: begin
        return 1'b0;
      end
    endcase
    report_min(st, mv);
    return 1'b1;
  endfunction

  function automatic logic [ACT_W-1:0] pick_action(input int w_ins, input int w_peek,
                                                   input int w_pop, input int w_rsvd);
    int r;
    r = $urandom_range(0, w_ins + w_peek + w_pop + w_rsvd - 1);
    if (r < w_ins) return ACT_INSERT;
    if (r < w_ins + w_peek) return ACT_PEEK;
    if (r < w_ins + w_peek + w_pop) return ACT_POP;
    return ACT_RSVD;
  endfunction

  function automatic logic [DATA_W-1:0] pick_value();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 4) return $urandom;
    if (sel < 7) return $urandom_range(0, 16) - 8;
    if (sel < 8) begin
      case ($urandom_range(0, 5))
        0: return 32'h8000_0000;
        1: return 32'h7FFF_FFFF;
        2: return 32'h8000_0001;
        3: return 32'h7FFF_FFFE;
        4: return 32'hFFFF_FFFF;
        default: return 32'h0000_0000;
      endcase
    end
    return $urandom_range(0, 2000) - 1000;
  endfunction

  task automatic send_request(input logic [ACT_W-1:0] act, input logic [DATA_W-1:0] val,
                              input logic typed, input logic [ST_W-1:0] st_typed,
                              input logic [DATA_W-1:0] mv_typed);
    logic [ST_W-1:0] st_pred;
    logic signed [DATA_W-1:0] mv_pred;
    bit produces;
    if (sent_count % 64 == 0) idle_mode = $urandom_range(0, 2) != 0;
    sent_count++;
    if (!quiet && idle_mode && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_valid <= 1'b1;
    action <= act;
    value <= val;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    // transfer accepted at this edge
    produces = predict_min(act, val, st_pred, mv_pred);
    if (produces) begin
      if (st_pred == ST_FULL) full_hits++;
      if (typed) expected_mins.push_back('{st_typed, mv_typed});
      else expected_mins.push_back('{st_pred, mv_pred});
    end
  endtask

  initial begin
    int n;
    logic [ACT_W-1:0] act;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < 25; i++) begin
      send_request(DIRECTED_ROWS[i].act, DIRECTED_ROWS[i].val, DIRECTED_ROWS[i].typed,
                   DIRECTED_ROWS[i].st, DIRECTED_ROWS[i].mv);
    end

    // mixed traffic around the empty queue
    n = 0;
    while (n < 200) begin
      act = pick_action(45, 12, 35, 8);
      send_request(act, pick_value(), 1'b0, ST_OK, '0);
      if (act != ACT_RSVD) n++;
    end

    in_valid <= 1'b0;
    do @(posedge clk); while (expected_mins.size() != 0);

    // fill until the store is full and a dozen inserts were rejected
    n = 0;
    while (full_hits < 12) begin
      act = pick_action(88, 5, 5, 2);
      send_request(act, pick_value(), 1'b0, ST_OK, '0);
      if (act != ACT_RSVD) n++;
      if (n == 100) long_hold_due = 1'b1;
    end

    // drain with deep sift-downs, no idling at the end
    n = 0;
    while (n < 350) begin
      if (n == 200) quiet = 1'b1;
      act = pick_action(15, 10, 70, 5);
      send_request(act, pick_value(), 1'b0, ST_OK, '0);
      if (act != ACT_RSVD) n++;
    end

    in_valid <= 1'b0;
    while (expected_mins.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    @(posedge clk);
    forever begin
      if (long_hold_due && !long_hold_done) begin
        out_stall <= 1'b1;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
        long_hold_done = 1'b1;
      end else if (quiet) begin
        out_stall <= 1'b0;
        @(posedge clk);
      end else if ($urandom_range(0, 2) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 17)) @(posedge clk);
      end else begin
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 40)) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else if (!rst && out_valid && !out_stall) begin
      if (expected_mins.size() == 0) begin
        $display("%0t: result with nothing pending: status=%0d min_value=%0d",
                 $time, status, min_value);
        errors++;
      end else begin
        oldest_min = expected_mins.pop_front();
        if (status !== oldest_min.st) begin
          $display("%0t: status mismatch: expected %0d actual %0d",
                   $time, oldest_min.st, status);
          errors++;
        end
        if (min_value !== oldest_min.mv) begin
          $display("%0t: min_value mismatch: expected %0d actual %0d",
                   $time, $signed(oldest_min.mv), min_value);
          errors++;
        end
      end
    end
  end

endmodule
